// ===== rtl/smtps_pkg.sv =====
package smtps_pkg;

  // Field widths fixed by the interface.
  localparam int FUNC_W  = 2;
  localparam int ADC_W   = 12;
  localparam int CNT_W   = 8;
  localparam int SUM_W   = 20;
  localparam int MOIST_W = 14;

  // Shared divider: the scaled difference is the widest dividend.
  localparam int DIV_DW = ADC_W + MOIST_W;
  localparam int DIV_VW = ADC_W;

  localparam int ADC_BITS_DEF    = 12;
  localparam int MAX_SAMPLES_DEF = 255;

  localparam logic [CNT_W-1:0]   COUNT_RESET = CNT_W'(10);
  localparam logic [MOIST_W-1:0] FULL_SCALE  = MOIST_W'(10000);

  localparam logic [FUNC_W-1:0] FUNC_MEASURE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_AIR     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_WATER   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/smtps_if.sv =====
interface smtps_in_if;
  import smtps_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ADC_W-1:0]  adc_sample;
  logic [ADC_W-1:0]  air_value;
  logic [ADC_W-1:0]  water_value;
  modport source (output valid, func, adc_sample, air_value, water_value, input ready);
  modport sink (input valid, func, adc_sample, air_value, water_value, output ready);
endinterface

interface smtps_cfg_if;
  import smtps_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface smtps_out_if;
  import smtps_pkg::*;
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  result_kind;
  logic [ADC_W-1:0]   average_count;
  logic [MOIST_W-1:0] moisture_hundredths;
  logic               calibration_invalid;
  modport source (output valid, result_kind, average_count, moisture_hundredths,
                  calibration_invalid, input ready);
  modport sink (input valid, result_kind, average_count, moisture_hundredths,
                calibration_invalid, output ready);
endinterface

// ===== rtl/soil_moisture_two_point_scaler.sv =====
// A sample that does not end a burst, and a baseline load, only update registers.
// A burst's last sample starts the divider; its result word takes one 26-step pass of the
// bit-serial divider for a calibration burst or a measurement that needs no scaling, and
// two 26-step passes for a scaled measurement.
// Throughput: one word per cycle inside a burst; ready stays low while the result is formed.
// Reset clears the burst, both baselines and the output valid; sample_count returns to 10.
module soil_moisture_two_point_scaler #(
  parameter int ADC_BITS    = smtps_pkg::ADC_BITS_DEF,
  parameter int MAX_SAMPLES = smtps_pkg::MAX_SAMPLES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  smtps_in_if.sink     in_i,
  smtps_cfg_if.sink    cfg_i,
  smtps_out_if.source  res_o
);
  import smtps_pkg::*;

  localparam logic [ADC_W-1:0] ADC_MASK = (ADC_BITS >= ADC_W) ? {ADC_W{1'b1}}
                                          : ADC_W'((32'd1 << ADC_BITS) - 32'd1);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_SAMPLES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV2 = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   count_q;
  logic [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]   taken_q;
  logic [FUNC_W-1:0]  mode_q;
  logic [ADC_W-1:0]   air_q, water_q;
  logic [FUNC_W-1:0]  kind_q;
  logic [ADC_W-1:0]   avg_q;
  logic [MOIST_W-1:0] moist_q;
  logic               inv_q;

  logic               out_valid_q;
  logic [FUNC_W-1:0]  out_kind_q;
  logic [ADC_W-1:0]   out_avg_q;
  logic [MOIST_W-1:0] out_moist_q;
  logic               out_inv_q;

  logic               accept, is_load, burst_end, emit_fire, need_scale;
  logic [CNT_W-1:0]   blen, taken_new;
  logic [SUM_W-1:0]   sum_new;
  logic [FUNC_W-1:0]  mode_new;
  logic [ADC_W-1:0]   avg_new, span, diff;

  logic               div_start;
  logic [DIV_DW-1:0]  div_dividend, div_quo;
  logic [DIV_VW-1:0]  div_divisor;
  div_stat_t          div_stat;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign is_load     = (in_i.func == FUNC_LOAD);

  always_comb begin
    if (count_q == '0) begin
      blen = CNT_W'(1);
    end else if (count_q > MAX_CNT) begin
      blen = MAX_CNT;
    end else begin
      blen = count_q;
    end
  end

  // A burst never runs past 255 samples, so the count cannot wrap here.
  assign taken_new = taken_q + CNT_W'(1);
  assign sum_new   = ((taken_q == '0) ? '0 : sum_q) + SUM_W'(in_i.adc_sample & ADC_MASK);
  assign mode_new  = (taken_q == '0) ? in_i.func : mode_q;
  assign burst_end = accept && !is_load && (taken_new >= blen);

  assign avg_new    = div_quo[ADC_W-1:0] & ADC_MASK;
  assign span       = air_q - water_q;
  assign diff       = air_q - avg_q;
  assign need_scale = (kind_q == FUNC_MEASURE) && (air_q > water_q) && (avg_q < air_q);
  assign emit_fire  = (state_q == S_EMIT) && (!out_valid_q || res_o.ready);

  // The divider averages the burst, then, where needed, scales the air-baseline distance.
  assign div_start    = burst_end || ((state_q == S_MUL) && need_scale);
  assign div_dividend = (state_q == S_MUL) ? DIV_DW'(diff) * DIV_DW'(FULL_SCALE)
                                           : DIV_DW'(sum_new);
  assign div_divisor  = (state_q == S_MUL) ? span : DIV_VW'(taken_new);

  smtps_div #(
    .DW (DIV_DW),
    .VW (DIV_VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (burst_end) state_d = S_DIV1;
      S_DIV1: if (div_stat.done) state_d = S_MUL;
      S_MUL:  state_d = need_scale ? S_DIV2 : S_EMIT;
      S_DIV2: if (div_stat.done) state_d = S_EMIT;
      S_EMIT: if (emit_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= COUNT_RESET;
      sum_q   <= '0;
      taken_q <= '0;
      mode_q  <= FUNC_MEASURE;
      air_q   <= '0;
      water_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        count_q <= cfg_i.data;
      end
      if (accept && is_load) begin
        air_q   <= in_i.air_value;
        water_q <= in_i.water_value;
      end else if (accept) begin
        sum_q   <= burst_end ? '0 : sum_new;
        taken_q <= burst_end ? '0 : taken_new;
        mode_q  <= mode_new;
      end
      if ((state_q == S_DIV1) && div_stat.done) begin
        if (kind_q == FUNC_AIR) begin
          air_q <= avg_new;
        end else if (kind_q == FUNC_WATER) begin
          water_q <= avg_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (burst_end) begin
      kind_q <= mode_new;
    end
    if ((state_q == S_DIV1) && div_stat.done) begin
      avg_q <= avg_new;
    end
    if (state_q == S_MUL) begin
      inv_q   <= !(air_q > water_q);
      moist_q <= '0;
    end
    if ((state_q == S_DIV2) && div_stat.done) begin
      moist_q <= (div_quo > DIV_DW'(FULL_SCALE)) ? FULL_SCALE : div_quo[MOIST_W-1:0];
    end
  end

  // Output register: the finished word waits here while a new burst starts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_kind_q  <= kind_q;
      out_avg_q   <= avg_q;
      out_moist_q <= moist_q;
      out_inv_q   <= inv_q;
    end
  end

  assign res_o.valid               = out_valid_q;
  assign res_o.result_kind         = out_kind_q;
  assign res_o.average_count       = out_avg_q;
  assign res_o.moisture_hundredths = out_moist_q;
  assign res_o.calibration_invalid = out_inv_q;

  a_burst_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_end |=> state_q == S_DIV1 && div_stat.busy) else $error("burst end missed divider");
  a_burst_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> taken_q == '0) else $error("burst left open while busy");
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.calibration_invalid |-> res_o.moisture_hundredths == '0)
    else $error("moisture given with invalid calibration");
  a_calib_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.result_kind != FUNC_MEASURE |-> res_o.moisture_hundredths == '0)
    else $error("moisture given for a calibration word");

endmodule

// ===== rtl/smtps_div.sv =====
module smtps_div #(
  parameter int DW = smtps_pkg::DIV_DW,
  parameter int VW = smtps_pkg::DIV_VW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DW-1:0]         dividend_i,
  input  logic [VW-1:0]         divisor_i,
  output logic [DW-1:0]         quotient_o,
  output smtps_pkg::div_stat_t  stat_o
);
  import smtps_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] div_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [VW:0]   trial, diff;
  logic          ge;

  // Restoring division, one quotient bit per cycle, MSB first.
  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    diff  = trial - {1'b0, div_q};
    ge    = ~diff[VW];
    rem_d = ge ? diff[VW-1:0] : trial[VW-1:0];
    quo_d = {quo_q[DW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q) else $error("done without a finished run");
  a_run_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("divider step count ran out while busy");

endmodule

// ===== bench/tb_soil_moisture_two_point_scaler.sv =====
`timescale 1ns / 100ps

module tb_soil_moisture_two_point_scaler;
  import smtps_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int SETTLE_TICKS = 80;
  localparam int WORD_TARGET  = 1300;

  typedef struct packed {
    logic [FUNC_W-1:0]  kind;
    logic [ADC_W-1:0]   avg;
    logic [MOIST_W-1:0] moist;
    logic               invalid;
  } reading_t;

  // Tracks the burst accumulator and the baselines, and keeps the readings still owed.
  class moisture_tracker;
    reading_t         owed_readings[$];
    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] sum_acc;
    logic [CNT_W-1:0] taken;
    logic [FUNC_W-1:0] mode;
    logic [ADC_W-1:0] air_bl;
    logic [ADC_W-1:0] water_bl;
    int unsigned      errors;

    function new();
      count_reg = COUNT_RESET;
      sum_acc   = '0;
      taken     = '0;
      mode      = FUNC_MEASURE;
      air_bl    = '0;
      water_bl  = '0;
      errors    = 0;
    endfunction

    function void write_count(logic [CNT_W-1:0] v);
      count_reg = v;
    endfunction

    function int unsigned pending();
      return owed_readings.size();
    endfunction

    function logic [MOIST_W-1:0] scale(logic [ADC_W-1:0] avg);
      longint unsigned q;
      if (air_bl <= water_bl || avg >= air_bl) return '0;
      q = (longint'(air_bl - avg) * 10000) / longint'(air_bl - water_bl);
      return (q > 10000) ? FULL_SCALE : MOIST_W'(q);
    endfunction

    function void note_word(logic [FUNC_W-1:0] func, logic [ADC_W-1:0] sample,
                            logic [ADC_W-1:0] air, logic [ADC_W-1:0] water);
      int unsigned n;
      int unsigned divisor;
      reading_t    r;
      if (func == FUNC_LOAD) begin
        air_bl   = air;
        water_bl = water;
        return;
      end
      if (taken == 0) begin
        mode    = func;
        sum_acc = '0;
      end
      sum_acc += sample;
      taken   += 1;
      n = (count_reg == 0) ? 1 : count_reg;
      if (n > MAX_SAMPLES_DEF) n = MAX_SAMPLES_DEF;
      if (taken != 0 && taken < n) return;
      divisor = (taken == 0) ? 256 : taken;
      r.avg   = ADC_W'(sum_acc / divisor);
      r.kind  = mode;
      r.moist = '0;
      sum_acc = '0;
      taken   = '0;
      if (r.kind == FUNC_AIR) air_bl = r.avg;
      else if (r.kind == FUNC_WATER) water_bl = r.avg;
      else r.moist = scale(r.avg);
      r.invalid = (air_bl <= water_bl);
      owed_readings.push_back(r);
    endfunction

    function void compare(string field, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_reading(reading_t got);
      reading_t exp_r;
      if (owed_readings.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual %p", $time, got);
        errors++;
        return;
      end
      exp_r = owed_readings.pop_front();
      compare("result_kind", exp_r.kind, got.kind);
      compare("average_count", exp_r.avg, got.avg);
      compare("moisture_hundredths", exp_r.moist, got.moist);
      compare("calibration_invalid", exp_r.invalid, got.invalid);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  smtps_in_if  in_if ();
  smtps_cfg_if cfg_if ();
  smtps_out_if res_if ();

  soil_moisture_two_point_scaler i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  moisture_tracker tracker = new();
  int unsigned     burst_left;
  int unsigned     words_sent;
  int unsigned     idle_cycles;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Sends one input word; the sender sometimes idles between bursts of random length.
  task automatic send_word(logic [FUNC_W-1:0] func, logic [ADC_W-1:0] sample,
                           logic [ADC_W-1:0] air, logic [ADC_W-1:0] water);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_if.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_if.valid       = 1'b1;
    in_if.func        = func;
    in_if.adc_sample  = sample;
    in_if.air_value   = air;
    in_if.water_value = water;
    do @(posedge clk); while (!in_if.ready);
    tracker.note_word(func, sample, air, water);
    words_sent++;
    @(negedge clk);
  endtask

  // The count register is only written once every owed reading has arrived.
  task automatic write_sample_count(logic [CNT_W-1:0] v);
    in_if.valid = 1'b0;
    burst_left  = 0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.data  = v;
    do @(posedge clk); while (!cfg_if.ready);
    tracker.write_count(v);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic run_directed();
    write_sample_count(8'd1);
    send_word(FUNC_LOAD, 12'd0, 12'd4095, 12'd0);
    send_word(FUNC_MEASURE, 12'd0, 12'd0, 12'd0);
    send_word(FUNC_MEASURE, 12'd4095, 12'd0, 12'd0);
    send_word(FUNC_MEASURE, 12'd2048, 12'd0, 12'd0);
    send_word(FUNC_AIR, 12'd3000, 12'd0, 12'd0);
    send_word(FUNC_WATER, 12'd1000, 12'd0, 12'd0);
    // Below the water baseline the scaled value overshoots and must clamp.
    send_word(FUNC_MEASURE, 12'd500, 12'd0, 12'd0);
    send_word(FUNC_LOAD, 12'd4095, 12'd0, 12'd0);
    send_word(FUNC_MEASURE, 12'd100, 12'd0, 12'd0);
    send_word(FUNC_LOAD, 12'd0, 12'd100, 12'd200);
    send_word(FUNC_MEASURE, 12'd150, 12'd0, 12'd0);
    send_word(FUNC_LOAD, 12'd0, 12'd4095, 12'd4094);
    send_word(FUNC_MEASURE, 12'd4094, 12'd0, 12'd0);
    // The mode of a burst is fixed by its first sample, and a load passes through it.
    write_sample_count(8'd3);
    send_word(FUNC_AIR, 12'd4095, 12'd0, 12'd0);
    send_word(FUNC_MEASURE, 12'd4095, 12'd0, 12'd0);
    send_word(FUNC_LOAD, 12'd0, 12'd3500, 12'd500);
    send_word(FUNC_WATER, 12'd4095, 12'd0, 12'd0);
    // Lowering the count mid-burst ends the burst at the next sample.
    write_sample_count(8'd5);
    send_word(FUNC_MEASURE, 12'd1000, 12'd0, 12'd0);
    send_word(FUNC_MEASURE, 12'd2000, 12'd0, 12'd0);
    send_word(FUNC_MEASURE, 12'd3000, 12'd0, 12'd0);
    write_sample_count(8'd2);
    send_word(FUNC_MEASURE, 12'd4000, 12'd0, 12'd0);
    write_sample_count(8'd0);
    send_word(FUNC_MEASURE, 12'd1234, 12'd0, 12'd0);
    send_word(FUNC_AIR, 12'd4095, 12'd0, 12'd0);
    send_word(FUNC_WATER, 12'd0, 12'd0, 12'd0);
  endtask

  task automatic run_random();
    int unsigned       count_menu[9] = '{0, 1, 1, 2, 3, 4, 7, 10, 16};
    int unsigned       phase;
    int unsigned       pick;
    int unsigned       cnt;
    int unsigned       n_words;
    int unsigned       style;
    int unsigned       lo;
    int unsigned       hi;
    logic [FUNC_W-1:0] burst_func;
    logic [FUNC_W-1:0] func;
    logic [ADC_W-1:0]  sample;
    logic [ADC_W-1:0]  air;
    logic [ADC_W-1:0]  water;
    burst_func = FUNC_MEASURE;
    for (phase = 0; words_sent < WORD_TARGET; phase++) begin
      if (phase == 4 || phase == 13) begin
        cnt = 255;
      end else begin
        pick = $urandom_range(0, 9);
        cnt  = (pick == 9) ? $urandom_range(1, 32) : count_menu[pick];
      end
      write_sample_count(CNT_W'(cnt));
      n_words = (cnt >= 200) ? 270 : $urandom_range(30, 90);
      style   = $urandom_range(0, 4);
      repeat (n_words) begin
        air   = ADC_W'($urandom_range(0, 4095));
        water = ADC_W'($urandom_range(0, 4095));
        if ($urandom_range(0, 99) < 6) begin
          func = FUNC_LOAD;
          if ($urandom_range(0, 9) < 7) begin
            air   = ADC_W'($urandom_range(2048, 4095));
            water = ADC_W'($urandom_range(0, 2047));
          end
        end else begin
          if (tracker.taken == 0) begin
            pick = $urandom_range(0, 99);
            burst_func = (pick < 60) ? FUNC_MEASURE : (pick < 80) ? FUNC_AIR : FUNC_WATER;
          end
          func = burst_func;
          if ($urandom_range(0, 99) < 5) func = FUNC_W'($urandom_range(0, 2));
        end
        case (style)
          0: begin
            sample = ADC_W'(4095);
          end
          1, 2: begin
            lo = (tracker.air_bl < tracker.water_bl) ? tracker.air_bl : tracker.water_bl;
            hi = (tracker.air_bl < tracker.water_bl) ? tracker.water_bl : tracker.air_bl;
            lo = (lo > 64) ? lo - 64 : 0;
            hi = (hi < 4031) ? hi + 64 : 4095;
            sample = ADC_W'($urandom_range(lo, hi));
          end
          default: begin
            sample = ADC_W'($urandom_range(0, 4095));
          end
        endcase
        send_word(func, sample, air, water);
      end
    end
  endtask

  // The receiver stalls on a rotating 16-bit pattern that is renewed now and then.
  initial begin
    logic [15:0] pattern;
    int unsigned ticks;
    res_if.ready = 1'b0;
    pattern = 16'hFFFF;
    ticks = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (ticks % 128 == 0) begin
        case ($urandom_range(0, 3))
          0: pattern = 16'hFFFF;
          1: pattern = 16'h0001 << $urandom_range(0, 15);
          default: pattern = 16'($urandom_range(0, 65535)) | 16'h0100;
        endcase
      end
      ticks++;
      res_if.ready <= pattern[0];
      pattern = {pattern[0], pattern[15:1]};
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      tracker.check_reading({res_if.result_kind, res_if.average_count,
                             res_if.moisture_hundredths, res_if.calibration_invalid});
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (cfg_if.valid && cfg_if.ready) ||
                 (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.func         = FUNC_MEASURE;
    in_if.adc_sample   = '0;
    in_if.air_value    = '0;
    in_if.water_value  = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.data        = '0;
    burst_left         = 0;
    words_sent         = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    run_directed();
    run_random();
    in_if.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
